// File: hw/rtl/jeud_pkg.sv
package jeud_pkg;

    // Decoder phase
    typedef enum logic [3:0] {
        PH_PLAIN = 4'd0,
        PH_ESC   = 4'd1,
        PH_HEX   = 4'd2,
        PH_SKIP1 = 4'd3,
        PH_SKIP2 = 4'd4,
        PH_LOW   = 4'd5
    } t_phase;

    // Up to four UTF-8 bytes produced by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } t_group;

    localparam logic [15:0] HI_SURR_LO   = 16'hD800;
    localparam logic [15:0] CP_BMP_LO    = 16'hD7FF;
    localparam logic [15:0] HI_SURR_HI   = 16'hDBFF;
    localparam logic [15:0] CP_BMP_HI_LO = 16'hE000;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // Hex digit: bit 4 set when valid, low nibble is the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // UTF-8 encoding; code point zero becomes the two-byte overlong form
    function automatic t_group utf8_encode(input logic [20:0] cp);
        t_group g;
        g.bytes = '0;
        if (cp != 21'd0 && cp <= 21'h7F) begin
            g.bytes[0] = cp[7:0];
            g.cnt      = 3'd1;
        end else if (cp <= 21'h7FF) begin
            g.bytes[0] = LEAD2 | {3'd0, cp[10:6]};
            g.bytes[1] = CONT | {2'd0, cp[5:0]};
            g.cnt      = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            g.bytes[0] = LEAD3 | {4'd0, cp[15:12]};
            g.bytes[1] = CONT | {2'd0, cp[11:6]};
            g.bytes[2] = CONT | {2'd0, cp[5:0]};
            g.cnt      = 3'd3;
        end else if (cp <= 21'h10FFFF) begin
            g.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
            g.bytes[1] = CONT | {2'd0, cp[17:12]};
            g.bytes[2] = CONT | {2'd0, cp[11:6]};
            g.bytes[3] = CONT | {2'd0, cp[5:0]};
            g.cnt      = 3'd4;
        end else begin
            g.cnt = 3'd0;
        end
        return g;
    endfunction

endpackage

// File: hw/rtl/jeud_in_if.sv
interface jeud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: hw/rtl/jeud_out_if.sv
interface jeud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: hw/rtl/jeud_decode.sv
module jeud_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    jeud_in_if.sink         i_in,
    output jeud_pkg::t_group o_grp,
    output logic            o_grp_valid,
    input  logic            i_grp_ready
);
    import jeud_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_phase      r_phase, n_phase;
    logic [15:0] r_hex, n_hex;
    logic [2:0]  r_dig, n_dig;
    logic        r_stop, n_stop;
    logic [9:0]  r_high, n_high;

    logic [4:0]  dv;
    logic [15:0] t_hex;
    logic        t_stop;
    logic [2:0]  t_dig;
    logic        t_done;
    logic        do_enc;
    logic        do_single;
    logic [7:0]  s_byte;
    logic [20:0] cp;
    t_group      grp;
    logic        fire;

    // One hex digit taken into the accumulator
    always_comb begin
        dv     = hex_digit(r_in_byte);
        t_hex  = (!r_stop && dv[4]) ? {r_hex[11:0], dv[3:0]} : r_hex;
        t_stop = r_stop || !dv[4];
        t_dig  = r_dig + 3'd1;
        t_done = (t_dig >= 3'd4);
    end

    // Next state and code point selection
    always_comb begin
        n_phase   = r_phase;
        n_hex     = r_hex;
        n_dig     = r_dig;
        n_stop    = r_stop;
        n_high    = r_high;
        do_enc    = 1'b0;
        do_single = 1'b0;
        s_byte    = r_in_byte;
        cp        = '0;
        case (r_phase)
            PH_ESC: begin
                n_phase = PH_PLAIN;
                case (r_in_byte)
                    CH_U: begin
                        n_hex   = '0;
                        n_dig   = '0;
                        n_stop  = 1'b0;
                        n_phase = PH_HEX;
                    end
                    CH_N:    begin do_single = 1'b1; s_byte = 8'h0A; end
                    CH_R:    begin do_single = 1'b1; s_byte = 8'h0D; end
                    CH_T:    begin do_single = 1'b1; s_byte = 8'h09; end
                    CH_B:    begin do_single = 1'b1; s_byte = 8'h08; end
                    CH_F:    begin do_single = 1'b1; s_byte = 8'h0C; end
                    default: begin do_single = 1'b1; end
                endcase
            end
            PH_HEX: begin
                n_hex  = t_hex;
                n_dig  = t_dig;
                n_stop = t_stop;
                if (t_done) begin
                    n_hex   = '0;
                    n_dig   = '0;
                    n_stop  = 1'b0;
                    n_phase = PH_PLAIN;
                    if (t_hex <= CP_BMP_LO) begin
                        do_enc = 1'b1;
                        cp     = {5'd0, t_hex};
                    end else if (t_hex <= HI_SURR_HI) begin
                        n_high  = 10'(t_hex - HI_SURR_LO);
                        n_phase = PH_SKIP1;
                    end else if (t_hex < CP_BMP_HI_LO) begin
                        // lone low surrogate decodes as code point zero
                        do_enc = 1'b1;
                    end else begin
                        do_enc = 1'b1;
                        cp     = {5'd0, t_hex};
                    end
                end
            end
            PH_SKIP1: begin
                n_phase = PH_SKIP2;
            end
            PH_SKIP2: begin
                n_hex   = '0;
                n_dig   = '0;
                n_stop  = 1'b0;
                n_phase = PH_LOW;
            end
            PH_LOW: begin
                n_hex  = t_hex;
                n_dig  = t_dig;
                n_stop = t_stop;
                if (t_done) begin
                    n_hex   = '0;
                    n_dig   = '0;
                    n_stop  = 1'b0;
                    n_phase = PH_PLAIN;
                    do_enc  = 1'b1;
                    cp      = {1'b0, r_high, t_hex[9:0]} + SUPP_BASE;
                end
            end
            default: begin
                n_phase = PH_PLAIN;
                if (r_in_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    do_single = 1'b1;
                end
            end
        endcase
    end

    // Result group for this byte
    always_comb begin
        grp = '0;
        if (do_enc) begin
            grp = utf8_encode(cp);
        end else if (do_single) begin
            grp.bytes[0] = s_byte;
            grp.cnt      = 3'd1;
        end
    end

    // Byte with no output retires at once; otherwise wait for the emitter
    assign fire        = r_in_valid && (grp.cnt == 3'd0 || i_grp_ready);
    assign i_in.ready  = !r_in_valid || fire;
    assign o_grp       = grp;
    assign o_grp_valid = r_in_valid && (grp.cnt != 3'd0);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_hex   <= '0;
            r_dig   <= '0;
            r_stop  <= 1'b0;
            r_high  <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_dig   <= n_dig;
            r_stop  <= n_stop;
            r_high  <= n_high;
        end
    end

endmodule

// File: hw/rtl/jeud_emit.sv
module jeud_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jeud_pkg::t_group i_grp,
    input  logic             i_grp_valid,
    output logic             o_grp_ready,
    jeud_out_if.source       o_out
);
    import jeud_pkg::*;

    logic            r_valid;
    logic [3:0][7:0] r_bytes;
    logic [1:0]      r_last_idx;
    logic [1:0]      r_idx;
    logic            at_last;
    logic            load;

    assign at_last     = (r_idx == r_last_idx);
    assign o_grp_ready = !r_valid || (o_out.ready && at_last);
    assign load        = i_grp_valid && o_grp_ready;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_bytes[r_idx];
    assign o_out.last_of_run = at_last;

    // Group register and byte pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && o_out.ready) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes    <= i_grp.bytes;
            r_last_idx <= 2'(i_grp.cnt - 3'd1);
        end
    end

endmodule

// File: hw/rtl/json_escape_to_utf8_decoder.sv
// Each input byte is registered, decoded, then held in the group register for o_out.
// Throughput: one input byte per cycle while each yields at most one output byte
// and o_out is ready; a byte yielding n UTF-8 bytes holds o_out until all are sent.
// Reset (i_rst_n low, synchronous): plain text phase, hex accumulator and
// surrogate register cleared, both pipeline registers empty.
module json_escape_to_utf8_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jeud_in_if.sink    i_in,
    jeud_out_if.source o_out
);
    import jeud_pkg::*;

    t_group grp;
    logic   grp_valid;
    logic   grp_ready;

    jeud_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_grp       (grp),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready)
    );

    jeud_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (grp),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .o_out       (o_out)
    );

endmodule

// File: tb/tb_json_escape_to_utf8_decoder.sv
`timescale 1ns / 100ps

module tb_json_escape_to_utf8_decoder;
    import jeud_pkg::*;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    // One decoded byte as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_utf8_byte;

    // Directed row: input byte, typed-in decoded bytes when typed is set
    typedef struct packed {
        logic [7:0]      in_byte;
        logic            typed;
        logic [2:0]      n;
        logic [0:3][7:0] o;
    } t_row;

    logic clk;
    logic rst_n;

    jeud_in_if  in_ch ();
    jeud_out_if out_ch ();

    json_escape_to_utf8_decoder dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Decoder shadow state
    t_phase      dec_phase;
    logic [15:0] dec_acc;
    logic [2:0]  dec_cnt;
    logic        dec_stop;
    logic [9:0]  dec_hi;

    t_utf8_byte  utf8_expect_q [$];
    logic [7:0]  token_q [$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    bit          idle_on = 1'b1;
    bit          rx_hold_req = 1'b0;

    // Plain bytes, every escape, a group led by a non-hex byte, then the top
    // surrogate pair with junk prefix bytes
    t_row dir_rows [$] = '{
        '{8'h00, 1'b1, 3'd1, 32'h00_000000},
        '{8'hFF, 1'b1, 3'd1, 32'hFF_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_N, 1'b1, 3'd1, 32'h0A_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_R, 1'b1, 3'd1, 32'h0D_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_T, 1'b1, 3'd1, 32'h09_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_B, 1'b1, 3'd1, 32'h08_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_F, 1'b1, 3'd1, 32'h0C_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_BSLASH, 1'b1, 3'd1, 32'h5C_000000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_U, 1'b0, 3'd0, 32'h0},
        '{8'h47, 1'b0, 3'd0, 32'h0},
        '{8'h31, 1'b0, 3'd0, 32'h0},
        '{8'h32, 1'b0, 3'd0, 32'h0},
        '{8'h33, 1'b1, 3'd2, 32'hC080_0000},
        '{CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{CH_U, 1'b0, 3'd0, 32'h0},
        '{8'h44, 1'b0, 3'd0, 32'h0},
        '{8'h62, 1'b0, 3'd0, 32'h0},
        '{8'h46, 1'b0, 3'd0, 32'h0},
        '{8'h66, 1'b0, 3'd0, 32'h0},
        '{8'h00, 1'b0, 3'd0, 32'h0},
        '{8'hFF, 1'b0, 3'd0, 32'h0},
        '{8'h46, 1'b0, 3'd0, 32'h0},
        '{8'h66, 1'b0, 3'd0, 32'h0},
        '{8'h46, 1'b0, 3'd0, 32'h0},
        '{8'h46, 1'b1, 3'd4, 32'hF48FBFBF}
    };

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("json_escape_to_utf8_decoder: mismatch");
            $finish;
        end
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    function automatic void hex_restart();
        dec_acc  = '0;
        dec_cnt  = '0;
        dec_stop = 1'b0;
    endfunction

    // Consume one byte of a four-byte group; true when the group is complete
    function automatic bit hex_absorb(input logic [7:0] c);
        int d;
        d = hex_nibble(c);
        if (!dec_stop && d >= 0) dec_acc = {dec_acc[11:0], 4'(d)};
        else dec_stop = 1'b1;
        dec_cnt = dec_cnt + 3'd1;
        return dec_cnt >= 3'd4;
    endfunction

    // UTF-8 bytes of a code point; zero takes the two-byte form
    function automatic int utf8_pack(input logic [20:0] cp, output logic [0:3][7:0] o);
        o = '0;
        if (cp != 21'd0 && cp < 21'h80) begin
            o[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            o[0] = {3'b110, cp[10:6]};
            o[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            o[0] = {4'b1110, cp[15:12]};
            o[1] = {2'b10, cp[11:6]};
            o[2] = {2'b10, cp[5:0]};
            return 3;
        end
        if (cp <= 21'h10FFFF) begin
            o[0] = {5'b11110, cp[20:18]};
            o[1] = {2'b10, cp[17:12]};
            o[2] = {2'b10, cp[11:6]};
            o[3] = {2'b10, cp[5:0]};
            return 4;
        end
        return 0;
    endfunction

    // Next-state and output of the unescaper for one accepted byte
    function automatic int predict_decode(input logic [7:0] c, output logic [0:3][7:0] o);
        int          n;
        logic [15:0] v;
        n = 0;
        o = '0;
        case (dec_phase)
            PH_ESC: begin
                dec_phase = PH_PLAIN;
                n = 1;
                case (c)
                    CH_U: begin
                        hex_restart();
                        dec_phase = PH_HEX;
                        n = 0;
                    end
                    CH_N:    o[0] = 8'h0A;
                    CH_R:    o[0] = 8'h0D;
                    CH_T:    o[0] = 8'h09;
                    CH_B:    o[0] = 8'h08;
                    CH_F:    o[0] = 8'h0C;
                    default: o[0] = c;
                endcase
            end
            PH_HEX: begin
                if (hex_absorb(c)) begin
                    v = dec_acc;
                    hex_restart();
                    dec_phase = PH_PLAIN;
                    if (v <= CP_BMP_LO) begin
                        n = utf8_pack({5'd0, v}, o);
                    end else if (v <= HI_SURR_HI) begin
                        // high surrogate: wait for the low half
                        dec_hi = v[9:0];
                        dec_phase = PH_SKIP1;
                    end else if (v < CP_BMP_HI_LO) begin
                        // lone low surrogate decodes as zero
                        n = utf8_pack(21'd0, o);
                    end else begin
                        n = utf8_pack({5'd0, v}, o);
                    end
                end
            end
            PH_SKIP1: dec_phase = PH_SKIP2;
            PH_SKIP2: begin
                hex_restart();
                dec_phase = PH_LOW;
            end
            PH_LOW: begin
                if (hex_absorb(c)) begin
                    n = utf8_pack({1'b0, dec_hi, dec_acc[9:0]} + SUPP_BASE, o);
                    hex_restart();
                    dec_phase = PH_PLAIN;
                end
            end
            default: begin
                dec_phase = PH_PLAIN;
                if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    o[0] = c;
                    n = 1;
                end
            end
        endcase
        return n;
    endfunction

    function automatic void queue_run(input int n, input logic [0:3][7:0] o);
        for (int i = 0; i < n; i++) begin
            utf8_expect_q.push_back('{data: o[i], last: (i == n - 1)});
        end
    endfunction

    // Offer one request, wait for it to be taken, then log what it should decode to
    task automatic send_request(input logic [7:0] b, input bit typed, input int n_typed,
                                input logic [0:3][7:0] o_typed);
        logic [0:3][7:0] o_pred;
        int              n_pred;
        while (idle_on && $urandom_range(0, 99) < 33) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        n_pred = predict_decode(b, o_pred);
        if (typed) queue_run(n_typed, o_typed);
        else queue_run(n_pred, o_pred);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (utf8_expect_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return 8'h30 + d;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + (d - 4'd10);
    endfunction

    // Four hex digits of v in mixed case; noisy swaps some for random bytes
    function automatic void add_hex(input logic [15:0] v, input bit noisy);
        for (int i = 3; i >= 0; i--) begin
            if (noisy && $urandom_range(0, 2) == 0) token_q.push_back(8'($urandom_range(0, 255)));
            else token_q.push_back(hex_char(v[i*4 +: 4]));
        end
    endfunction

    function automatic logic [15:0] bmp_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 16'h7F));
            1: return 16'($urandom_range(16'h80, 16'h7FF));
            2: return 16'($urandom_range(16'h800, 16'hD7FF));
            3: return 16'($urandom_range(16'hDC00, 16'hDFFF));
            4: return 16'($urandom_range(16'hE000, 16'hFFFF));
            default: begin
                case ($urandom_range(0, 7))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'hD7FF;
                    5: return 16'hDC00;
                    6: return 16'hE000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // One random piece of string text: mostly well-formed escapes
    function automatic void build_token();
        int          kind;
        logic [15:0] lo;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            token_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 40) begin
            token_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 8))
                0: token_q.push_back(CH_N);
                1: token_q.push_back(CH_R);
                2: token_q.push_back(CH_T);
                3: token_q.push_back(CH_B);
                4: token_q.push_back(CH_F);
                5: token_q.push_back(CH_BSLASH);
                6: token_q.push_back(8'h22);
                default: token_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else if (kind < 65) begin
            token_q.push_back(CH_BSLASH);
            token_q.push_back(CH_U);
            add_hex(bmp_value(), 1'b0);
        end else if (kind < 90) begin
            // surrogate pair, sometimes with odd prefix or broken low half
            token_q.push_back(CH_BSLASH);
            token_q.push_back(CH_U);
            add_hex(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
            if ($urandom_range(0, 3) != 0) begin
                token_q.push_back(CH_BSLASH);
                token_q.push_back(CH_U);
            end else begin
                token_q.push_back(8'($urandom_range(0, 255)));
                token_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) != 0) lo = 16'($urandom_range(16'hDC00, 16'hDFFF));
            else lo = 16'($urandom_range(0, 16'hFFFF));
            add_hex(lo, $urandom_range(0, 7) == 0);
        end else begin
            token_q.push_back(CH_BSLASH);
            token_q.push_back(CH_U);
            add_hex(16'($urandom_range(0, 16'hFFFF)), 1'b1);
        end
    endfunction

    // Result side: random back-pressure plus one long hold-off
    initial begin
        int         hold_left;
        t_utf8_byte exp_b;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (utf8_expect_q.size() == 0) begin
                    $error("out_byte: expected none, got %02h", out_ch.out_byte);
                    fail_cnt++;
                end else begin
                    exp_b = utf8_expect_q.pop_front();
                    if (out_ch.out_byte !== exp_b.data) begin
                        $error("out_byte: expected %02h, got %02h", exp_b.data, out_ch.out_byte);
                        fail_cnt++;
                    end
                    if (out_ch.last_of_run !== exp_b.last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               exp_b.last, out_ch.last_of_run);
                        fail_cnt++;
                    end
                end
            end
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 33);
            end
        end
    end

    // Request side
    initial begin
        int sent;
        bit hold_done;
        bit drain_done;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        dec_phase = PH_PLAIN;
        hex_restart();
        dec_hi = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].in_byte, dir_rows[i].typed, int'(dir_rows[i].n),
                         dir_rows[i].o);
        end

        while (sent < RANDOM_ITEMS) begin
            idle_on = !(sent >= 150 && sent < 260);
            if (!hold_done && sent >= 60) begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (!drain_done && sent >= 320) begin
                wait_drained();
                drain_done = 1'b1;
            end
            build_token();
            while (token_q.size() != 0) begin
                send_request(token_q.pop_front(), 1'b0, 0, '0);
                sent++;
            end
        end

        // Let the tail of the output drain, then let the bench idle before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0) begin
            $display("json_escape_to_utf8_decoder: match");
        end else begin
            $display("json_escape_to_utf8_decoder: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/jeud_pkg.sv
hw/rtl/jeud_in_if.sv
hw/rtl/jeud_out_if.sv
hw/rtl/jeud_decode.sv
hw/rtl/jeud_emit.sv
hw/rtl/json_escape_to_utf8_decoder.sv
tb/tb_json_escape_to_utf8_decoder.sv
